// ----- hdl/mcg_pkg.sv -----
// ----------------------------------------------------------------------------
// mcg_pkg: shared constants, types and tables for the metronome click generator
// Widths of the beat stream, register indexes and the constant envelope and
// sine lookup tables built at elaboration.
// ----------------------------------------------------------------------------
package mcg_pkg;

  // field and state widths
  localparam int FRAME_W  = 48;
  localparam int NB_W     = 64;
  localparam int FRAC_W   = 16;
  localparam int PERIOD_W = 36;
  localparam int WARM_W   = 20;
  localparam int PHASE_W  = 32;
  localparam int BEAT_W   = 32;
  localparam int SAMPLE_W = 16;

  // click and table geometry
  localparam int CLICK_FRAMES = 1024;
  localparam int POS_W        = $clog2(CLICK_FRAMES + 1);
  localparam int ENV_DEPTH    = 1024;
  localparam int ENV_AW       = $clog2(ENV_DEPTH);
  localparam int SINE_DEPTH   = 1024;
  localparam int SIN_AW       = $clog2(SINE_DEPTH);
  localparam int SIN_W        = 15;
  localparam int AMP_W        = 15;
  localparam int AMP_Q15      = 18022;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 36;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUDIBLE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_NORMAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ACCENT  = 3'd4;

  // register reset values
  localparam logic [PERIOD_W-1:0] RST_BEAT_PERIOD = 36'd1572864000;
  localparam logic [WARM_W-1:0]   RST_WARMUP      = 20'd14400;
  localparam logic [PHASE_W-1:0]  RST_STEP_NORMAL = 32'd118111601;
  localparam logic [PHASE_W-1:0]  RST_STEP_ACCENT = 32'd157482134;

  typedef logic [15:0]      env_tab_t [ENV_DEPTH];
  typedef logic [SIN_W-1:0] sin_tab_t [SINE_DEPTH];

  // exp(-7 x) envelope, q30 recursion rounded to q0.16
  function automatic env_tab_t build_env();
    env_tab_t    t;
    logic [63:0] e;
    logic [63:0] v;
    e = 64'd1 << 30;
    for (int i = 0; i < ENV_DEPTH; i++) begin
      v    = (e + 64'd8192) >> 14;
      t[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      e    = (e * 64'd1066426823 + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  // quarter sine, taylor series in q30 horner form rounded to q15
  function automatic sin_tab_t build_sine();
    sin_tab_t    t;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] inner;
    logic [63:0] s;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      y     = 64'd1686629713 * 64'(i) / SINE_DEPTH;
      y2    = (y * y) >> 30;
      inner = 64'd1 << 30;
      inner = (64'd1 << 30) - ((y2 * inner) >> 30) / 64'd156;
      inner = (64'd1 << 30) - ((y2 * inner) >> 30) / 64'd110;
      inner = (64'd1 << 30) - ((y2 * inner) >> 30) / 64'd72;
      inner = (64'd1 << 30) - ((y2 * inner) >> 30) / 64'd42;
      inner = (64'd1 << 30) - ((y2 * inner) >> 30) / 64'd20;
      inner = (64'd1 << 30) - ((y2 * inner) >> 30) / 64'd6;
      s     = (((y * inner) >> 30) + (64'd1 << 14)) >> 15;
      t[i]  = (s > 64'd32767) ? 15'h7FFF : s[SIN_W-1:0];
    end
    return t;
  endfunction

  localparam env_tab_t ENV_TABLE  = build_env();
  localparam sin_tab_t SINE_TABLE = build_sine();

endpackage

// ----- hdl/mcg_if.sv -----
// ----------------------------------------------------------------------------
// mcg_if: valid/ready stream interfaces of the click generator
// Frame request channel and rendered frame channel.
// ----------------------------------------------------------------------------

// frame request: one beat per audio frame
interface mcg_in_if;
  logic valid;
  logic ready;
  logic restart;
  logic end_of_buffer;

  modport source (output valid, output restart, output end_of_buffer, input ready);
  modport sink   (input valid, input restart, input end_of_buffer, output ready);
endinterface

// rendered frame with tick information
interface mcg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mcg_pkg::SAMPLE_W-1:0] sample_out;
  logic                                tick_start;
  logic        [mcg_pkg::FRAME_W-1:0]  tick_frame;
  logic        [mcg_pkg::BEAT_W-1:0]   tick_number;
  logic                                buffer_last;

  modport source (output valid, output sample_out, output tick_start, output tick_frame,
                  output tick_number, output buffer_last, input ready);
  modport sink   (input valid, input sample_out, input tick_start, input tick_frame,
                  input tick_number, input buffer_last, output ready);
endinterface

// ----- hdl/metronome_click_generator.sv -----
// ----------------------------------------------------------------------------
// metronome_click_generator: beat scheduler and click synthesizer
// Turns a stream of frame requests into click audio plus beat tick flags.
// ----------------------------------------------------------------------------
// usage
//   in_i carries one beat per audio frame (restart, end_of_buffer); out_o
//   returns one beat per frame with the click sample, the tick flag, the
//   frame index, the beat index and the buffer end flag.
//   the cfg port writes the beat period, warm-up, mute and the two phase
//   steps; write it only while no frame is in flight.
// pipeline and throughput
//   a frame is accepted every cycle while in_i.ready stays high. the beat
//   scheduler and phase accumulator update in the accepting cycle, then
//   come address, table read, envelope scaling and the sine multiply, one
//   register stage each, the first loaded at the accepting edge.
// reset
//   clears the pipeline, loads the register defaults and schedules the first
//   beat after the warm-up; the click starts idle.
// stalls
//   when out_o.ready is low the pipeline keeps taking frames until all four
//   stages are full, then in_i.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module metronome_click_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mcg_in_if.sink                           in_i,
  mcg_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [mcg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mcg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int FRAME_W = mcg_pkg::FRAME_W;
  localparam int NB_W    = mcg_pkg::NB_W;
  localparam int FRAC_W  = mcg_pkg::FRAC_W;
  localparam int PHASE_W = mcg_pkg::PHASE_W;
  localparam int BEAT_W  = mcg_pkg::BEAT_W;
  localparam int POS_W   = mcg_pkg::POS_W;
  localparam int ENV_AW  = mcg_pkg::ENV_AW;
  localparam int SIN_AW  = mcg_pkg::SIN_AW;
  localparam int SIN_W   = mcg_pkg::SIN_W;
  localparam int AMP_W   = mcg_pkg::AMP_W;
  localparam int IDX_W   = SIN_AW + 2;

  // per-beat side information carried along the pipeline
  typedef struct packed {
    logic               tick;
    logic [FRAME_W-1:0] frame;
    logic [BEAT_W-1:0]  number;
    logic               last;
    logic               en;
    logic               neg;
    logic               peak;
  } side_t;

  // configuration registers
  logic [mcg_pkg::PERIOD_W-1:0] period_q;
  logic [mcg_pkg::WARM_W-1:0]   warm_q;
  logic                         audible_q;
  logic [PHASE_W-1:0]           step_norm_q;
  logic [PHASE_W-1:0]           step_acc_q;

  // run state
  logic [FRAME_W-1:0] frame_q,  frame_d;
  logic [NB_W-1:0]    nb_q,     nb_d;
  logic [BEAT_W-1:0]  beat_q,   beat_d;
  logic [POS_W-1:0]   pos_q,    pos_d;
  logic [PHASE_W-1:0] phase_q,  phase_d;

  // pipeline
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept;

  side_t              side1_q, side2_q, side3_q, side4_q;
  logic [ENV_AW-1:0]  env_addr1_q;
  logic [SIN_AW-1:0]  sin_addr1_q;
  logic [15:0]        env2_q;
  logic [SIN_W-1:0]   sin2_q;
  logic [AMP_W-1:0]   amp3_q;
  logic [SIN_W-1:0]   sin3_q;
  logic [mcg_pkg::SAMPLE_W-1:0] sample4_q;

  // scheduler combinational signals
  logic [FRAME_W-1:0] cur_frame;
  logic [NB_W-1:0]    cur_nb;
  logic [BEAT_W-1:0]  cur_beat;
  logic [POS_W-1:0]   cur_pos;
  logic [PHASE_W-1:0] cur_phase;
  logic [FRAME_W-1:0] beat_ip;
  logic [NB_W:0]      nb_sum;
  logic               tick_w;
  logic               active_w;
  logic [PHASE_W-1:0] samp_phase;
  logic [POS_W-1:0]   samp_pos;
  logic [IDX_W-1:0]   sin_idx;
  logic [SIN_AW-1:0]  sin_j;
  logic [ENV_AW-1:0]  env_addr_w;
  logic [SIN_AW-1:0]  sin_addr_w;
  side_t              side_w;

  // sample arithmetic
  logic [31:0]        amp_full;
  logic [SIN_W-1:0]   sin_eff;
  logic [30:0]        mag_full;
  logic [15:0]        mag;

  // handshake: a stage loads when it is empty or its content moves on
  assign rdy4   = !v4_q || out_o.ready;
  assign rdy3   = !v3_q || rdy4;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign in_i.ready = rdy1;
  assign accept = in_i.valid && rdy1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= mcg_pkg::RST_BEAT_PERIOD;
      warm_q      <= mcg_pkg::RST_WARMUP;
      audible_q   <= 1'b1;
      step_norm_q <= mcg_pkg::RST_STEP_NORMAL;
      step_acc_q  <= mcg_pkg::RST_STEP_ACCENT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mcg_pkg::REG_BEAT_PERIOD: period_q    <= cfg_data_i[mcg_pkg::PERIOD_W-1:0];
        mcg_pkg::REG_WARMUP:      warm_q      <= cfg_data_i[mcg_pkg::WARM_W-1:0];
        mcg_pkg::REG_AUDIBLE:     audible_q   <= cfg_data_i[0];
        mcg_pkg::REG_STEP_NORMAL: step_norm_q <= cfg_data_i[PHASE_W-1:0];
        mcg_pkg::REG_STEP_ACCENT: step_acc_q  <= cfg_data_i[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // beat scheduler, click position and phase accumulator
  always_comb begin
    if (in_i.restart) begin
      cur_frame = '0;
      cur_nb    = {{(NB_W-mcg_pkg::WARM_W-FRAC_W){1'b0}}, warm_q, {FRAC_W{1'b0}}};
      cur_beat  = '0;
      cur_pos   = POS_W'(mcg_pkg::CLICK_FRAMES);
      cur_phase = '0;
    end else begin
      cur_frame = frame_q;
      cur_nb    = nb_q;
      cur_beat  = beat_q;
      cur_pos   = pos_q;
      cur_phase = phase_q;
    end

    beat_ip = cur_nb[NB_W-1:FRAC_W];
    tick_w  = (cur_frame > beat_ip) ||
              ((cur_frame == beat_ip) && (cur_nb[FRAC_W-1:0] == '0));
    nb_sum  = {1'b0, cur_nb} + (NB_W+1)'(period_q);

    nb_d       = cur_nb;
    beat_d     = cur_beat;
    samp_pos   = cur_pos;
    samp_phase = cur_phase;
    if (tick_w) begin
      nb_d       = nb_sum[NB_W] ? {NB_W{1'b1}} : nb_sum[NB_W-1:0];
      beat_d     = cur_beat + BEAT_W'(1);
      samp_pos   = '0;
      samp_phase = '0;
    end

    active_w = samp_pos < POS_W'(mcg_pkg::CLICK_FRAMES);
    pos_d    = active_w ? samp_pos + POS_W'(1) : samp_pos;
    phase_d  = samp_phase;
    if (active_w && audible_q) begin
      phase_d = samp_phase + ((beat_d[1:0] == 2'd1) ? step_acc_q : step_norm_q);
    end
    frame_d = cur_frame + FRAME_W'(1);

    // table addresses: envelope by position, sine by quadrant with mirroring
    env_addr_w = ENV_AW'((POS_W + ENV_AW)'(samp_pos) * mcg_pkg::ENV_DEPTH
                         / mcg_pkg::CLICK_FRAMES);
    sin_idx    = samp_phase[PHASE_W-1 -: IDX_W];
    sin_j      = sin_idx[SIN_AW-1:0];
    sin_addr_w = sin_idx[SIN_AW] ? (~sin_j + SIN_AW'(1)) : sin_j;

    side_w.tick   = tick_w;
    side_w.frame  = cur_frame;
    side_w.number = tick_w ? cur_beat : '0;
    side_w.last   = in_i.end_of_buffer;
    side_w.en     = active_w && audible_q;
    side_w.neg    = sin_idx[SIN_AW+1];
    side_w.peak   = sin_idx[SIN_AW] && (sin_j == '0);
  end

  // run state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      nb_q    <= {{(NB_W-mcg_pkg::WARM_W-FRAC_W){1'b0}}, mcg_pkg::RST_WARMUP, {FRAC_W{1'b0}}};
      beat_q  <= '0;
      pos_q   <= POS_W'(mcg_pkg::CLICK_FRAMES);
      phase_q <= '0;
    end else if (accept) begin
      frame_q <= frame_d;
      nb_q    <= nb_d;
      beat_q  <= beat_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: table addresses
  always_ff @(posedge clk_i) begin
    if (accept) begin
      side1_q     <= side_w;
      env_addr1_q <= env_addr_w;
      sin_addr1_q <= sin_addr_w;
    end
  end

  // stage 2: registered table reads
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      side2_q <= side1_q;
      env2_q  <= mcg_pkg::ENV_TABLE[env_addr1_q];
      sin2_q  <= mcg_pkg::SINE_TABLE[sin_addr1_q];
    end
  end

  // stage 3: envelope times click amplitude
  assign amp_full = 32'(env2_q) * 32'(mcg_pkg::AMP_Q15) + 32'd32768;
  assign sin_eff  = side2_q.peak ? {SIN_W{1'b1}} : sin2_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      side3_q <= side2_q;
      amp3_q  <= amp_full[16 +: AMP_W];
      sin3_q  <= sin_eff;
    end
  end

  // stage 4: amplitude times sine, sign and mute
  assign mag_full = 31'(amp3_q) * 31'(sin3_q) + 31'd16384;
  assign mag      = mag_full[30:15];

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      side4_q   <= side3_q;
      sample4_q <= !side3_q.en ? '0 : (side3_q.neg ? (~mag + 16'd1) : mag);
    end
  end

  // output beat
  assign out_o.valid       = v4_q;
  assign out_o.sample_out  = sample4_q;
  assign out_o.tick_start  = side4_q.tick;
  assign out_o.tick_frame  = side4_q.frame;
  assign out_o.tick_number = side4_q.number;
  assign out_o.buffer_last = side4_q.last;

  // a restart makes the accepted frame frame zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.restart |=> frame_q == FRAME_W'(1))
    else $error("restart did not clear the frame counter");

  // a tick restarts the click and advances the beat count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && tick_w |=> pos_q == POS_W'(1) && beat_q == $past(cur_beat) + BEAT_W'(1))
    else $error("tick did not restart the click");

  // beat index is zero unless a tick is flagged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.tick_start |-> out_o.tick_number == '0)
    else $error("beat index set without a tick");

  // click amplitude stays within the click gain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.sample_out <= 16'sd18022) && (out_o.sample_out >= -16'sd18022))
    else $error("sample exceeds click amplitude");

  // an empty output stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v4_q |-> in_i.ready)
    else $error("input stalled with an empty output stage");

endmodule
